@@ rtl/core/perlin_noise_2d_sampler_assert.svh @@
// Assertion macros for the noise sampler core.
// Relies on the including module having clock and reset in scope.
`ifndef PERLIN_NOISE_2D_SAMPLER_ASSERT_SVH
`define PERLIN_NOISE_2D_SAMPLER_ASSERT_SVH

// Same-cycle implication.
`define PNDS_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pnds: same-cycle check failed");

// Next-cycle implication.
`define PNDS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pnds: next-cycle check failed");

`endif

@@ rtl/core/pnds_pkg.sv @@
// Shared constants, op codes and gradient helper for the noise sampler.
// No dependencies.
`timescale 1ns / 1ps

package pnds_pkg;

   localparam int GRID_COLS  = 64;
   localparam int GRID_ROWS  = 64;
   localparam int COL_BITS   = $clog2(GRID_COLS);
   localparam int ROW_BITS   = $clog2(GRID_ROWS);
   localparam int BANK_AW    = (COL_BITS - 1) + (ROW_BITS - 1);
   localparam int BANK_DEPTH = 1 << BANK_AW;
   localparam int NUM_BANKS  = 4;

   localparam int COORD_W    = 16;
   localparam int FRAC_W     = 16;
   localparam int DIV_STEPS  = COORD_W + FRAC_W;
   localparam int CELL_W     = 11;
   localparam int REM_W      = 10;
   localparam int GRID_IDX_W = 8;
   localparam int CODE_W     = 3;
   localparam int NOISE_W    = 20;
   localparam int OFS_W      = 12;
   localparam int DOT_W      = 13;

   localparam logic [CELL_W-1:0] CELL_MAX   = 11'd1024;
   localparam logic [CELL_W-1:0] CELL_MIN   = 11'd1;
   localparam logic [CELL_W-1:0] CELL_RESET = 11'd16;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef enum logic {
      CSR_CELL_WIDTH  = 1'b0,
      CSR_CELL_HEIGHT = 1'b1
   } csr_index_type;

   // Gradients: (0,1) (0,-1) (1,0) (-1,0) (1,1) (-1,-1) (1,-1) (-1,1)
   function automatic logic signed [DOT_W-1:0] grad_dot(
      input logic [CODE_W-1:0]       code,
      input logic signed [OFS_W-1:0] dx,
      input logic signed [OFS_W-1:0] dy
   );
      logic signed [DOT_W-1:0] ex;
      logic signed [DOT_W-1:0] ey;
      logic signed [DOT_W-1:0] res;
      ex = DOT_W'(dx);
      ey = DOT_W'(dy);
      unique case (code)
         3'd0: res = ey;
         3'd1: res = -ey;
         3'd2: res = ex;
         3'd3: res = -ex;
         3'd4: res = ex + ey;
         3'd5: res = -ex - ey;
         3'd6: res = ex - ey;
         default: res = ey - ex;
      endcase
      return res;
   endfunction

endpackage

@@ rtl/core/pnds_if.sv @@
// Valid/ready channel interfaces for request and response beats.
// Depends on pnds_pkg.
`timescale 1ns / 1ps

interface pnds_req_if import pnds_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  op;
   logic [COORD_W-1:0]    sample_x;
   logic [COORD_W-1:0]    sample_y;
   logic [GRID_IDX_W-1:0] grid_col;
   logic [GRID_IDX_W-1:0] grid_row;
   logic [CODE_W-1:0]     gradient_code;

   modport source (output valid, op, sample_x, sample_y, grid_col, grid_row, gradient_code,
                   input ready);
   modport sink   (input valid, op, sample_x, sample_y, grid_col, grid_row, gradient_code,
                   output ready);
endinterface

interface pnds_rsp_if import pnds_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [NOISE_W-1:0] noise_value;
   logic                      out_of_range;

   modport source (output valid, noise_value, out_of_range, input ready);
   modport sink   (input valid, noise_value, out_of_range, output ready);
endinterface

@@ rtl/core/perlin_noise_2d_sampler.sv @@
// 2D gradient noise sampler: one request beat in, one response beat out, in order.
// Accepts a beat every cycle while no response is held. Stages: input register,
// a 32-step restoring divider for coordinate/cell and in-cell fraction, eight
// arithmetic stages, output register. The gradient table is split into four
// parity banks so all four corners are read together. A held response stalls
// the whole pipe. Depends on pnds_pkg, pnds_if and the assert macros.
`timescale 1ns / 1ps

`include "perlin_noise_2d_sampler_assert.svh"

module perlin_noise_2d_sampler import pnds_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   pnds_req_if.sink              req_ch,
   pnds_rsp_if.source            rsp_ch,
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [CELL_W-1:0]     csr_wdata
);

   typedef struct packed {
      op_type                op;
      logic                  oor;
      logic [GRID_IDX_W-1:0] col;
      logic [GRID_IDX_W-1:0] row;
      logic [CODE_W-1:0]     code;
      logic [COORD_W-1:0]    x;
      logic [COORD_W-1:0]    y;
      logic [CELL_W-1:0]     w;
      logic [CELL_W-1:0]     h;
      logic [REM_W-1:0]      rx;
      logic [REM_W-1:0]      ry;
      logic [REM_W-1:0]      xl;
      logic [REM_W-1:0]      yl;
      logic [DIV_STEPS-1:0]  qx;
      logic [DIV_STEPS-1:0]  qy;
   } div_type;

   typedef struct packed {
      op_type op;
      logic   oor;
   } tag_type;

   typedef struct packed {
      tag_type                 tag;
      logic                    xpar;
      logic                    ypar;
      logic signed [OFS_W-1:0] dx0;
      logic signed [OFS_W-1:0] dx1;
      logic signed [OFS_W-1:0] dy0;
      logic signed [OFS_W-1:0] dy1;
      logic [FRAC_W-1:0]       ux;
      logic [FRAC_W-1:0]       uy;
      logic [FRAC_W-1:0]       u2x;
      logic [FRAC_W-1:0]       u2y;
   } e1_type;

   typedef struct packed {
      tag_type                 tag;
      logic [FRAC_W-1:0]       u3x;
      logic [FRAC_W-1:0]       u3y;
      logic [19:0]             kx;
      logic [19:0]             ky;
      logic signed [DOT_W-1:0] c00;
      logic signed [DOT_W-1:0] c01;
      logic signed [DOT_W-1:0] c10;
      logic signed [DOT_W-1:0] c11;
   } e2_type;

   typedef struct packed {
      tag_type                 tag;
      logic [FRAC_W:0]         fx;
      logic [FRAC_W:0]         fy;
      logic signed [DOT_W-1:0] c00;
      logic signed [DOT_W-1:0] c10;
      logic signed [DOT_W:0]   da;
      logic signed [DOT_W:0]   db;
   } e3_type;

   typedef struct packed {
      tag_type                 tag;
      logic [FRAC_W:0]         fy;
      logic signed [DOT_W-1:0] c00;
      logic signed [DOT_W-1:0] c10;
      logic signed [31:0]      pa;
      logic signed [31:0]      pb;
   } e4_type;

   typedef struct packed {
      tag_type            tag;
      logic [FRAC_W:0]    fy;
      logic signed [31:0] rowa;
      logic signed [31:0] rowb;
   } e5_type;

   typedef struct packed {
      tag_type            tag;
      logic [FRAC_W:0]    fy;
      logic signed [31:0] rowa;
      logic signed [32:0] rd;
   } e6_type;

   typedef struct packed {
      tag_type            tag;
      logic signed [31:0] rowa;
      logic signed [50:0] pt;
   } e7_type;

   typedef struct packed {
      tag_type            tag;
      logic signed [50:0] total;
   } e8_type;

   localparam int XL_STEP = COORD_W - 1;

   logic [CELL_W-1:0] cell_w_ff;
   logic [CELL_W-1:0] cell_h_ff;
   logic              adv;

   div_type div_ff     [0:DIV_STEPS];
   logic    div_vld_ff [0:DIV_STEPS];

   e1_type e1_ff, e1_in;
   e2_type e2_ff, e2_in;
   e3_type e3_ff, e3_in;
   e4_type e4_ff, e4_in;
   e5_type e5_ff, e5_in;
   e6_type e6_ff, e6_in;
   e7_type e7_ff, e7_in;
   e8_type e8_ff, e8_in;
   logic   e1_vld_ff, e2_vld_ff, e3_vld_ff, e4_vld_ff;
   logic   e5_vld_ff, e6_vld_ff, e7_vld_ff, e8_vld_ff;

   logic                      out_vld_ff;
   op_type                    out_op_ff;
   logic signed [NOISE_W-1:0] out_noise_ff, out_noise_in;
   logic                      out_oor_ff;

   logic [CODE_W-1:0] rd_ff [NUM_BANKS];

   assign adv          = !out_vld_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_w_ff <= CELL_RESET;
         cell_h_ff <= CELL_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_CELL_WIDTH) begin
            cell_w_ff <= csr_wdata;
         end else begin
            cell_h_ff <= csr_wdata;
         end
      end
   end

   function automatic logic [CELL_W-1:0] eff_cell(input logic [CELL_W-1:0] r);
      logic [CELL_W-1:0] res;
      if (r == '0) begin
         res = CELL_MIN;
      end else if (r > CELL_MAX) begin
         res = CELL_MAX;
      end else begin
         res = r;
      end
      return res;
   endfunction

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         div_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         div_vld_ff[0] <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff[0].op   <= op_type'(req_ch.op);
         div_ff[0].oor  <= ({1'b0, req_ch.grid_col} >= (GRID_IDX_W+1)'(GRID_COLS)) ||
                           ({1'b0, req_ch.grid_row} >= (GRID_IDX_W+1)'(GRID_ROWS));
         div_ff[0].col  <= req_ch.grid_col;
         div_ff[0].row  <= req_ch.grid_row;
         div_ff[0].code <= req_ch.gradient_code;
         div_ff[0].x    <= req_ch.sample_x;
         div_ff[0].y    <= req_ch.sample_y;
         div_ff[0].w    <= eff_cell(cell_w_ff);
         div_ff[0].h    <= eff_cell(cell_h_ff);
         div_ff[0].rx   <= '0;
         div_ff[0].ry   <= '0;
         div_ff[0].xl   <= '0;
         div_ff[0].yl   <= '0;
         div_ff[0].qx   <= '0;
         div_ff[0].qy   <= '0;
      end
   end

   // Restoring divider, one quotient bit per stage
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      logic              bx;
      logic              by;
      logic [CELL_W-1:0] tx;
      logic [CELL_W-1:0] ty;
      div_type           div_in;

      if (k < COORD_W) begin : g_int
         assign bx = div_ff[k].x[COORD_W-1-k];
         assign by = div_ff[k].y[COORD_W-1-k];
      end else begin : g_frac
         assign bx = 1'b0;
         assign by = 1'b0;
      end

      always_comb begin
         div_in = div_ff[k];
         tx     = {div_ff[k].rx, bx};
         ty     = {div_ff[k].ry, by};
         if (tx >= div_ff[k].w) begin
            div_in.rx = REM_W'(tx - div_ff[k].w);
            div_in.qx = {div_ff[k].qx[DIV_STEPS-2:0], 1'b1};
         end else begin
            div_in.rx = tx[REM_W-1:0];
            div_in.qx = {div_ff[k].qx[DIV_STEPS-2:0], 1'b0};
         end
         if (ty >= div_ff[k].h) begin
            div_in.ry = REM_W'(ty - div_ff[k].h);
            div_in.qy = {div_ff[k].qy[DIV_STEPS-2:0], 1'b1};
         end else begin
            div_in.ry = ty[REM_W-1:0];
            div_in.qy = {div_ff[k].qy[DIV_STEPS-2:0], 1'b0};
         end
         if (k == XL_STEP) begin
            div_in.xl = div_in.rx;
            div_in.yl = div_in.ry;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            div_vld_ff[k+1] <= div_vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            div_ff[k+1] <= div_in;
         end
      end
   end

   // Gradient table: four banks by column and row parity
   logic [COL_BITS-1:0] xc, xc1;
   logic [ROW_BITS-1:0] yc, yc1;
   logic [1:0]          wr_bank;
   logic [BANK_AW-1:0]  wr_addr;
   logic                wr_go;

   assign xc      = div_ff[DIV_STEPS].qx[FRAC_W +: COL_BITS];
   assign yc      = div_ff[DIV_STEPS].qy[FRAC_W +: ROW_BITS];
   assign xc1     = COL_BITS'(xc + 1'b1);
   assign yc1     = ROW_BITS'(yc + 1'b1);
   assign wr_bank = {div_ff[DIV_STEPS].col[0], div_ff[DIV_STEPS].row[0]};
   assign wr_addr = {div_ff[DIV_STEPS].col[COL_BITS-1:1], div_ff[DIV_STEPS].row[ROW_BITS-1:1]};
   assign wr_go   = adv && div_vld_ff[DIV_STEPS] && (div_ff[DIV_STEPS].op == OP_LOAD) &&
                    !div_ff[DIV_STEPS].oor;

   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      localparam logic BC = 1'(b / 2);
      localparam logic BR = 1'(b % 2);
      logic [CODE_W-1:0]   bank_mem [BANK_DEPTH];
      logic [COL_BITS-1:0] colb;
      logic [ROW_BITS-1:0] rowb;
      logic [BANK_AW-1:0]  rd_addr;

      assign colb    = (xc[0] == BC) ? xc : xc1;
      assign rowb    = (yc[0] == BR) ? yc : yc1;
      assign rd_addr = {colb[COL_BITS-1:1], rowb[ROW_BITS-1:1]};

      always_ff @(posedge clock) begin
         if (wr_go && (wr_bank == 2'(b))) begin
            bank_mem[wr_addr] <= div_ff[DIV_STEPS].code;
         end
         if (adv) begin
            rd_ff[b] <= bank_mem[rd_addr];
         end
      end
   end

   // E1: range check, offsets, u squared
   logic [31:0] sqx, sqy;

   always_comb begin
      e1_in.tag.op = div_ff[DIV_STEPS].op;
      if (div_ff[DIV_STEPS].op == OP_LOAD) begin
         e1_in.tag.oor = div_ff[DIV_STEPS].oor;
      end else begin
         e1_in.tag.oor =
            (div_ff[DIV_STEPS].qx[DIV_STEPS-1:FRAC_W] >= COORD_W'(GRID_COLS - 1)) ||
            (div_ff[DIV_STEPS].qy[DIV_STEPS-1:FRAC_W] >= COORD_W'(GRID_ROWS - 1));
      end
      e1_in.xpar = xc[0];
      e1_in.ypar = yc[0];
      e1_in.dx0  = $signed({2'b00, div_ff[DIV_STEPS].xl});
      e1_in.dy0  = $signed({2'b00, div_ff[DIV_STEPS].yl});
      e1_in.dx1  = $signed({2'b00, div_ff[DIV_STEPS].xl}) - $signed({1'b0, div_ff[DIV_STEPS].w});
      e1_in.dy1  = $signed({2'b00, div_ff[DIV_STEPS].yl}) - $signed({1'b0, div_ff[DIV_STEPS].h});
      e1_in.ux   = div_ff[DIV_STEPS].qx[FRAC_W-1:0];
      e1_in.uy   = div_ff[DIV_STEPS].qy[FRAC_W-1:0];
      sqx        = 32'(e1_in.ux) * 32'(e1_in.ux);
      sqy        = 32'(e1_in.uy) * 32'(e1_in.uy);
      e1_in.u2x  = sqx[31:16];
      e1_in.u2y  = sqy[31:16];
   end

   // E2: u cubed, fade polynomial tail, corner dots
   logic [31:0]       cux, cuy;
   logic [19:0]       mx, my;
   logic [35:0]       pkx, pky;
   logic [CODE_W-1:0] g00, g01, g10, g11;

   always_comb begin
      unique case ({e1_ff.xpar, e1_ff.ypar})
         2'b00: begin
            g00 = rd_ff[0]; g01 = rd_ff[2]; g10 = rd_ff[1]; g11 = rd_ff[3];
         end
         2'b01: begin
            g00 = rd_ff[1]; g01 = rd_ff[3]; g10 = rd_ff[0]; g11 = rd_ff[2];
         end
         2'b10: begin
            g00 = rd_ff[2]; g01 = rd_ff[0]; g10 = rd_ff[3]; g11 = rd_ff[1];
         end
         default: begin
            g00 = rd_ff[3]; g01 = rd_ff[1]; g10 = rd_ff[2]; g11 = rd_ff[0];
         end
      endcase
      cux       = 32'(e1_ff.u2x) * 32'(e1_ff.ux);
      cuy       = 32'(e1_ff.u2y) * 32'(e1_ff.uy);
      mx        = 20'd983040 - (20'(e1_ff.ux) * 20'd6);
      my        = 20'd983040 - (20'(e1_ff.uy) * 20'd6);
      pkx       = 36'(e1_ff.ux) * 36'(mx);
      pky       = 36'(e1_ff.uy) * 36'(my);
      e2_in.tag = e1_ff.tag;
      e2_in.u3x = cux[31:16];
      e2_in.u3y = cuy[31:16];
      e2_in.kx  = 20'd655360 - pkx[35:16];
      e2_in.ky  = 20'd655360 - pky[35:16];
      e2_in.c00 = grad_dot(g00, e1_ff.dx0, e1_ff.dy0);
      e2_in.c01 = grad_dot(g01, e1_ff.dx1, e1_ff.dy0);
      e2_in.c10 = grad_dot(g10, e1_ff.dx0, e1_ff.dy1);
      e2_in.c11 = grad_dot(g11, e1_ff.dx1, e1_ff.dy1);
   end

   // E3: fade values, corner differences
   logic [35:0] fpx, fpy;

   always_comb begin
      fpx       = 36'(e2_ff.u3x) * 36'(e2_ff.kx);
      fpy       = 36'(e2_ff.u3y) * 36'(e2_ff.ky);
      e3_in.tag = e2_ff.tag;
      e3_in.fx  = fpx[32:16];
      e3_in.fy  = fpy[32:16];
      e3_in.c00 = e2_ff.c00;
      e3_in.c10 = e2_ff.c10;
      e3_in.da  = (DOT_W+1)'(e2_ff.c01) - (DOT_W+1)'(e2_ff.c00);
      e3_in.db  = (DOT_W+1)'(e2_ff.c11) - (DOT_W+1)'(e2_ff.c10);
   end

   // E4..E8: lerps along x then y
   always_comb begin
      e4_in.tag = e3_ff.tag;
      e4_in.fy  = e3_ff.fy;
      e4_in.c00 = e3_ff.c00;
      e4_in.c10 = e3_ff.c10;
      e4_in.pa  = 32'(e3_ff.da) * 32'($signed({1'b0, e3_ff.fx}));
      e4_in.pb  = 32'(e3_ff.db) * 32'($signed({1'b0, e3_ff.fx}));

      e5_in.tag  = e4_ff.tag;
      e5_in.fy   = e4_ff.fy;
      e5_in.rowa = (32'(e4_ff.c00) <<< 16) + e4_ff.pa;
      e5_in.rowb = (32'(e4_ff.c10) <<< 16) + e4_ff.pb;

      e6_in.tag  = e5_ff.tag;
      e6_in.fy   = e5_ff.fy;
      e6_in.rowa = e5_ff.rowa;
      e6_in.rd   = 33'(e5_ff.rowb) - 33'(e5_ff.rowa);

      e7_in.tag  = e6_ff.tag;
      e7_in.rowa = e6_ff.rowa;
      e7_in.pt   = 51'(e6_ff.rd) * 51'($signed({1'b0, e6_ff.fy}));

      e8_in.tag   = e7_ff.tag;
      e8_in.total = (51'(e7_ff.rowa) <<< 16) + e7_ff.pt;
   end

   // Output: floor to Q12.8, saturate, zero loads and errors
   logic signed [26:0] res;

   always_comb begin
      res = $signed(e8_ff.total[50:24]);
      if ((e8_ff.tag.op == OP_LOAD) || e8_ff.tag.oor) begin
         out_noise_in = '0;
      end else if (res > 27'sd524287) begin
         out_noise_in = 20'sd524287;
      end else if (res < -27'sd524288) begin
         out_noise_in = -20'sd524288;
      end else begin
         out_noise_in = res[NOISE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_vld_ff  <= 1'b0;
         e2_vld_ff  <= 1'b0;
         e3_vld_ff  <= 1'b0;
         e4_vld_ff  <= 1'b0;
         e5_vld_ff  <= 1'b0;
         e6_vld_ff  <= 1'b0;
         e7_vld_ff  <= 1'b0;
         e8_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         e1_vld_ff  <= div_vld_ff[DIV_STEPS];
         e2_vld_ff  <= e1_vld_ff;
         e3_vld_ff  <= e2_vld_ff;
         e4_vld_ff  <= e3_vld_ff;
         e5_vld_ff  <= e4_vld_ff;
         e6_vld_ff  <= e5_vld_ff;
         e7_vld_ff  <= e6_vld_ff;
         e8_vld_ff  <= e7_vld_ff;
         out_vld_ff <= e8_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e1_ff        <= e1_in;
         e2_ff        <= e2_in;
         e3_ff        <= e3_in;
         e4_ff        <= e4_in;
         e5_ff        <= e5_in;
         e6_ff        <= e6_in;
         e7_ff        <= e7_in;
         e8_ff        <= e8_in;
         out_op_ff    <= e8_ff.tag.op;
         out_oor_ff   <= e8_ff.tag.oor;
         out_noise_ff <= out_noise_in;
      end
   end

   assign rsp_ch.valid        = out_vld_ff;
   assign rsp_ch.noise_value  = out_noise_ff;
   assign rsp_ch.out_of_range = out_oor_ff;

   `PNDS_ASSERT_IMPLY(a_div_rem, div_vld_ff[DIV_STEPS], CELL_W'(div_ff[DIV_STEPS].rx) < div_ff[DIV_STEPS].w)
   `PNDS_ASSERT_IMPLY(a_fade_max, e3_vld_ff, (e3_ff.fx <= 17'd65536) && (e3_ff.fy <= 17'd65536))
   `PNDS_ASSERT_IMPLY(a_load_zero, out_vld_ff && (out_op_ff == OP_LOAD), out_noise_ff == '0)
   `PNDS_ASSERT_NEXT(a_stall_hold, !adv, out_vld_ff && $stable(out_noise_ff) && $stable(out_oor_ff))

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the 2D gradient noise sampler.
// Depends on pnds_pkg, the pnds_req_if/pnds_rsp_if interfaces and the sampler RTL.
`timescale 1ns / 1ps

module testbench;
   import pnds_pkg::*;

   typedef struct {
      op_type          op;
      bit [15:0]       sx;
      bit [15:0]       sy;
      bit [7:0]        col;
      bit [7:0]        row;
      bit [2:0]        code;
   } noise_req;

   typedef struct {
      logic signed [NOISE_W-1:0] noise;
      bit                        oor;
   } noise_rsp;

   class noise_scoreboard;
      bit [2:0]  grad_code[GRID_COLS*GRID_ROWS];
      int        cell_w = 16;
      int        cell_h = 16;
      noise_rsp  pending_rsp[$];
      int        errors = 0;
      int        gx[8] = '{0, 0, 1, -1, 1, -1, 1, -1};
      int        gy[8] = '{1, -1, 0, 0, 1, -1, -1, 1};

      function int clamp_cell(int r);
         if (r == 0) return 1;
         if (r > 1024) return 1024;
         return r;
      endfunction

      function longint fade(longint unsigned u);
         longint unsigned u2, u3, k;
         u2 = (u * u) >> 16;
         u3 = (u2 * u) >> 16;
         k  = 655360 - ((u * (983040 - 6 * u)) >> 16);
         return longint'((u3 * k) >> 16);
      endfunction

      function longint dot(int c, int r, longint dx, longint dy);
         int g;
         g = int'(grad_code[c * GRID_ROWS + r]);
         return gx[g] * dx + gy[g] * dy;
      endfunction

      function void note(noise_req b);
         noise_rsp e;
         int w, h, xi, yi, xl, yl;
         longint fx, fy, c00, c01, c10, c11, ra, rb, total, res;
         e.noise = '0;
         e.oor = 0;
         if (b.op == OP_LOAD) begin
            if (b.col >= GRID_COLS || b.row >= GRID_ROWS) e.oor = 1;
            else grad_code[b.col * GRID_ROWS + b.row] = b.code;
         end else begin
            w = clamp_cell(cell_w);
            h = clamp_cell(cell_h);
            xi = b.sx / w; yi = b.sy / h;
            xl = b.sx % w; yl = b.sy % h;
            if (xi >= GRID_COLS - 1 || yi >= GRID_ROWS - 1) begin
               e.oor = 1;
            end else begin
               fx = fade((longint'(xl) << 16) / w);
               fy = fade((longint'(yl) << 16) / h);
               c00 = dot(xi, yi, xl, yl);
               c01 = dot(xi + 1, yi, xl - w, yl);
               c10 = dot(xi, yi + 1, xl, yl - h);
               c11 = dot(xi + 1, yi + 1, xl - w, yl - h);
               ra = c00 * 65536 + (c01 - c00) * fx;
               rb = c10 * 65536 + (c11 - c10) * fx;
               total = ra * 65536 + (rb - ra) * fy;
               res = total >>> 24;
               if (res > 524287) res = 524287;
               if (res < -524288) res = -524288;
               e.noise = res[NOISE_W-1:0];
            end
         end
         pending_rsp.push_back(e);
      endfunction

      function void check(logic signed [NOISE_W-1:0] noise, logic oor);
         noise_rsp e;
         if (pending_rsp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected beat: noise %0d oor %b", noise, oor);
            return;
         end
         e = pending_rsp.pop_front();
         if (noise !== e.noise || oor !== e.oor) begin
            errors++;
            if (errors <= 10)
               $display("beat mismatch: expected noise %0d oor %b, got noise %0d oor %b",
                        e.noise, e.oor, noise, oor);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic csr_index = CSR_CELL_WIDTH;
   logic [CELL_W-1:0] csr_wdata = '0;

   pnds_req_if req_ch();
   pnds_rsp_if rsp_ch();

   perlin_noise_2d_sampler uut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   noise_scoreboard sc = new();
   bit   loaded[GRID_COLS*GRID_ROWS];
   int   cur_w = 16, cur_h = 16;
   int   hold_off = 0;
   int   send_calm = 0, recv_calm = 0;
   int   cycles = 0;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   initial begin
      req_ch.valid = 0;
      req_ch.op = OP_LOAD;
      req_ch.sample_x = '0;
      req_ch.sample_y = '0;
      req_ch.grid_col = '0;
      req_ch.grid_row = '0;
      req_ch.gradient_code = '0;
      rsp_ch.ready = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_ch.valid && rsp_ch.ready) sc.check(rsp_ch.noise_value, rsp_ch.out_of_range);

   function automatic int draw_gap(ref int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) calm = $urandom_range(10, 40);
      return $urandom_range(0, 18);
   endfunction

   initial begin
      int gap;
      @(negedge clock);
      wait (!reset);
      forever begin
         if (hold_off > 0) begin
            rsp_ch.ready <= 0;
            repeat (hold_off) @(negedge clock);
            hold_off = 0;
         end
         gap = draw_gap(recv_calm);
         if (gap > 0) begin
            rsp_ch.ready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready <= 1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   task automatic send(noise_req b);
      int gap;
      gap = draw_gap(send_calm);
      if (gap > 0) begin
         req_ch.valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1;
      req_ch.op <= b.op;
      req_ch.sample_x <= b.sx;
      req_ch.sample_y <= b.sy;
      req_ch.grid_col <= b.col;
      req_ch.grid_row <= b.row;
      req_ch.gradient_code <= b.code;
      do @(posedge clock); while (!req_ch.ready);
      sc.note(b);
      if (b.op == OP_LOAD && b.col < GRID_COLS && b.row < GRID_ROWS)
         loaded[b.col * GRID_ROWS + b.row] = 1;
      @(negedge clock);
   endtask

   task automatic load(int c, int r, int code);
      noise_req b;
      b.op = OP_LOAD;
      b.sx = 16'($urandom); b.sy = 16'($urandom);
      b.col = 8'(c); b.row = 8'(r); b.code = 3'(code);
      send(b);
   endtask

   // fill any missing corner first so no unwritten entry is read
   task automatic sample(int x, int y);
      noise_req b;
      int w, h, xi, yi;
      w = sc.clamp_cell(cur_w);
      h = sc.clamp_cell(cur_h);
      xi = x / w; yi = y / h;
      if (xi < GRID_COLS - 1 && yi < GRID_ROWS - 1)
         for (int i = 0; i < 4; i++)
            if (!loaded[(xi + i[0]) * GRID_ROWS + yi + i[1]])
               load(xi + i[0], yi + i[1], $urandom_range(0, 7));
      b.op = OP_SAMPLE;
      b.sx = 16'(x); b.sy = 16'(y);
      b.col = 8'($urandom); b.row = 8'($urandom); b.code = 3'($urandom);
      send(b);
   endtask

   task automatic drain();
      req_ch.valid <= 0;
      while (sc.pending_rsp.size() != 0) @(negedge clock);
      repeat (45) @(negedge clock);
   endtask

   task automatic write_cells(int w, int h);
      drain();
      csr_wr_en <= 1;
      csr_index <= CSR_CELL_WIDTH;
      csr_wdata <= CELL_W'(w);
      @(negedge clock);
      csr_index <= CSR_CELL_HEIGHT;
      csr_wdata <= CELL_W'(h);
      @(negedge clock);
      csr_wr_en <= 0;
      sc.cell_w = w; sc.cell_h = h;
      cur_w = w; cur_h = h;
   endtask

   task automatic random_phase(int n);
      int w, h;
      w = sc.clamp_cell(cur_w);
      h = sc.clamp_cell(cur_h);
      repeat (n) begin
         case ($urandom_range(0, 9))
            0, 1: load($urandom_range(0, GRID_COLS - 1), $urandom_range(0, GRID_ROWS - 1),
                       $urandom_range(0, 7));
            2: load($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 7));
            3: sample($urandom_range(0, 65535), $urandom_range(0, 65535));
            default: sample($urandom_range(0, (GRID_COLS - 1) * w - 1),
                            $urandom_range(0, (GRID_ROWS - 1) * h - 1));
         endcase
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      for (int c = 0; c < 2; c++)
         for (int r = 0; r < 2; r++)
            for (int g = 0; g < 2; g++) load(c, r, c * 4 + r * 2 + g);
      load(64, 0, 7);
      load(0, 255, 0);
      load(255, 255, 5);
      load(63, 63, 7);
      sample(0, 0);
      sample(15, 15);
      sample(8, 3);
      sample(62 * 16 + 15, 62 * 16 + 15);
      sample(63 * 16, 0);
      sample(0, 63 * 16);
      sample(65535, 65535);
      random_phase(40);

      // long receiver hold-off while beats keep coming
      hold_off = 300;
      random_phase(30);
      drain();
      random_phase(10);

      write_cells(1, 1);
      random_phase(30);
      write_cells(1024, 1024);
      sample(64511, 64511);
      random_phase(25);
      write_cells(0, 2047);
      random_phase(25);
      write_cells(7, 300);
      random_phase(25);
      write_cells(1000, 3);
      random_phase(25);

      drain();
      sc.errors += sc.pending_rsp.size();
      if (sc.errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
